// ----- sv/websocket_frame_deframer_assert.svh -----
// assertion macros for the websocket frame deframer
`ifndef WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH
`define WEBSOCKET_FRAME_DEFRAMER_ASSERT_SVH

`ifndef SYNTHESIS

`define WSFD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wsfd assertion failed");

`define WSFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wsfd assertion failed");

`else

`define WSFD_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define WSFD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- sv/wsfd_pkg.sv -----
// shared constants of the websocket frame deframer
`timescale 1ns / 1ps

package wsfd_pkg;

  localparam int unsigned LIMIT_W = 63;
  localparam int unsigned LEN_W   = 64;

  localparam logic [LIMIT_W-1:0] MAX_BYTES_DEFAULT = 63'd16777216;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [2:0] KIND_TEXT  = 3'd0;
  localparam logic [2:0] KIND_BIN   = 3'd1;
  localparam logic [2:0] KIND_PING  = 3'd2;
  localparam logic [2:0] KIND_CLOSE = 3'd3;
  localparam logic [2:0] KIND_FAIL  = 3'd4;

  localparam logic [1:0] CODE_NONE  = 2'd0;
  localparam logic [1:0] CODE_PROTO = 2'd1;
  localparam logic [1:0] CODE_BIG   = 2'd2;

  localparam logic [6:0] LEN16_CODE = 7'd126;
  localparam logic [6:0] LEN64_CODE = 7'd127;
  localparam logic [6:0] CTRL_MAX   = 7'd125;
  localparam logic [15:0] LEN16_MIN = 16'd126;

endpackage

// ----- sv/websocket_frame_deframer.sv -----
// websocket frame deframer: header parse, unmasking and frame checks in one pass
// Takes one received byte per transaction on the slave side and gives at most one
// result per byte on the master side. Every byte is processed in the cycle it is
// accepted and its result lands in a single output register, so the block sustains
// one byte per cycle; the input stalls only while that output register holds a
// result the consumer has not yet taken. Frame headers of 2 to 14 bytes give no
// result except on failure or for an empty non-pong frame. Non-pong payload bytes are
// unmasked and streamed with their kind; a message that later ends in a failure result
// (kind 4, close code 1 for 1002 or 2 for 1009) must be discarded by the consumer. After
// a failure or a received close the block keeps accepting bytes and drops them. The user
// writes the length limit via cfg_we/cfg_data while no frame is in flight; not enforced.
`timescale 1ns / 1ps
`include "websocket_frame_deframer_assert.svh"

module websocket_frame_deframer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [wsfd_pkg::LIMIT_W-1:0] cfg_data,       // max_payload_bytes
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // rx_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata,   // payload_byte, message_end, fail_code
  output logic [3:0]                   m_axis_tuser,   // has_byte, frame_kind
  output logic                         m_axis_tlast    // frame_end
);

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_MASK,
    PH_DATA,
    PH_CLOSED
  } phase_t;

  phase_t                       phase, phase_next;
  logic [3:0]                   header_index, header_index_next;
  logic                         frame_fin, frame_fin_next;
  logic [3:0]                   frame_opcode, frame_opcode_next;
  logic [6:0]                   length_code, length_code_next;
  logic                         frame_masked, frame_masked_next;
  logic [wsfd_pkg::LEN_W-1:0]   remaining_length, remaining_length_next;
  logic [31:0]                  mask_key, mask_key_next;
  logic [1:0]                   mask_position, mask_position_next;
  logic                         in_fragment, in_fragment_next;
  logic                         message_is_binary, message_is_binary_next;
  logic [wsfd_pkg::LEN_W-1:0]   message_length, message_length_next;
  logic                         header_fault, header_fault_next;
  logic [wsfd_pkg::LIMIT_W-1:0] max_payload_bytes;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_has;
  logic [2:0] out_kind;
  logic       out_fend;
  logic       out_mend;
  logic [1:0] out_code;

  logic       res_valid;
  logic [7:0] res_byte;
  logic       res_has;
  logic [2:0] res_kind;
  logic       res_fend;
  logic       res_mend;
  logic [1:0] res_code;

  logic                       accept;
  logic [wsfd_pkg::LEN_W-1:0] limit_ext;
  logic [wsfd_pkg::LEN_W-1:0] hdr_len;
  logic                       len_bad;
  logic                       len_over;
  logic                       msg_over;
  logic [wsfd_pkg::LEN_W-1:0] msg_sum;
  logic                       frag_bad;
  logic [7:0]                 key_byte;
  logic [7:0]                 data_out;
  logic [2:0]                 cur_kind;
  logic                       ext_done;
  logic                       do_finish;
  logic [7:0]                 fin_byte;
  logic                       fin_has;
  logic                       op_ok;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_code, out_mend, out_byte};
  assign m_axis_tuser  = {out_kind, out_has};
  assign m_axis_tlast  = out_fend;

  always_comb begin
    limit_ext = {1'b0, max_payload_bytes};

    // header length as the frame declares it
    if (length_code == wsfd_pkg::LEN16_CODE || length_code == wsfd_pkg::LEN64_CODE) begin
      hdr_len = remaining_length;
    end else begin
      hdr_len = {57'd0, length_code};
    end

    len_bad = header_fault;
    if (length_code == wsfd_pkg::LEN16_CODE) begin
      if (hdr_len[15:0] < wsfd_pkg::LEN16_MIN) len_bad = 1'b1;
    end else if (length_code == wsfd_pkg::LEN64_CODE) begin
      if (hdr_len[63] || hdr_len[63:16] == 48'd0) len_bad = 1'b1;
    end
    if (frame_opcode[3] &&
        (!frame_fin || (|hdr_len[63:7]) || hdr_len[6:0] > wsfd_pkg::CTRL_MAX)) begin
      len_bad = 1'b1;
    end

    len_over = hdr_len > limit_ext;
    msg_over = message_length > limit_ext;
    msg_sum  = message_length + hdr_len;
    frag_bad = (frame_opcode == wsfd_pkg::OP_CONT) ? !in_fragment : in_fragment;

    case (mask_position)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
    data_out = s_axis_tdata ^ key_byte;

    case (frame_opcode)
      wsfd_pkg::OP_TEXT:  cur_kind = wsfd_pkg::KIND_TEXT;
      wsfd_pkg::OP_BIN:   cur_kind = wsfd_pkg::KIND_BIN;
      wsfd_pkg::OP_CONT:  cur_kind = message_is_binary ? wsfd_pkg::KIND_BIN
                                                       : wsfd_pkg::KIND_TEXT;
      wsfd_pkg::OP_CLOSE: cur_kind = wsfd_pkg::KIND_CLOSE;
      default:            cur_kind = wsfd_pkg::KIND_PING;
    endcase

    ext_done = (length_code == wsfd_pkg::LEN16_CODE) ? (header_index == 4'd1)
                                                     : (header_index == 4'd7);

    op_ok = (s_axis_tdata[3:0] inside {wsfd_pkg::OP_CONT, wsfd_pkg::OP_TEXT,
                                       wsfd_pkg::OP_BIN, wsfd_pkg::OP_CLOSE,
                                       wsfd_pkg::OP_PING, wsfd_pkg::OP_PONG});

    phase_next             = phase;
    header_index_next      = header_index;
    frame_fin_next         = frame_fin;
    frame_opcode_next      = frame_opcode;
    length_code_next       = length_code;
    frame_masked_next      = frame_masked;
    remaining_length_next  = remaining_length;
    mask_key_next          = mask_key;
    mask_position_next     = mask_position;
    in_fragment_next       = in_fragment;
    message_is_binary_next = message_is_binary;
    message_length_next    = message_length;
    header_fault_next      = header_fault;

    res_valid = 1'b0;
    res_byte  = 8'd0;
    res_has   = 1'b0;
    res_kind  = wsfd_pkg::KIND_TEXT;
    res_fend  = 1'b0;
    res_mend  = 1'b0;
    res_code  = wsfd_pkg::CODE_NONE;

    do_finish = 1'b0;
    fin_byte  = 8'd0;
    fin_has   = 1'b0;

    if (accept) begin
      case (phase)
        PH_HDR0: begin
          frame_fin_next    = s_axis_tdata[7];
          frame_opcode_next = s_axis_tdata[3:0];
          header_fault_next = (s_axis_tdata[6:4] != 3'd0) || !op_ok;
          phase_next        = PH_HDR1;
        end
        PH_HDR1: begin
          frame_masked_next     = s_axis_tdata[7];
          length_code_next      = s_axis_tdata[6:0];
          remaining_length_next = '0;
          header_index_next     = 4'd0;
          mask_key_next         = 32'd0;
          if (!s_axis_tdata[7]) header_fault_next = 1'b1;
          if (s_axis_tdata[6:0] == wsfd_pkg::LEN16_CODE ||
              s_axis_tdata[6:0] == wsfd_pkg::LEN64_CODE) begin
            phase_next = PH_EXT;
          end else if (s_axis_tdata[7]) begin
            phase_next = PH_MASK;
          end else begin
            // unmasked header ends here, always a protocol error
            phase_next = PH_CLOSED;
            res_valid  = 1'b1;
            res_kind   = wsfd_pkg::KIND_FAIL;
            res_code   = wsfd_pkg::CODE_PROTO;
          end
        end
        PH_EXT: begin
          remaining_length_next = {remaining_length[55:0], s_axis_tdata};
          header_index_next     = header_index + 4'd1;
          if (ext_done) begin
            header_index_next = 4'd0;
            if (frame_masked) begin
              phase_next = PH_MASK;
            end else begin
              phase_next = PH_CLOSED;
              res_valid  = 1'b1;
              res_kind   = wsfd_pkg::KIND_FAIL;
              res_code   = wsfd_pkg::CODE_PROTO;
            end
          end
        end
        PH_MASK: begin
          mask_key_next     = {mask_key[23:0], s_axis_tdata};
          header_index_next = header_index + 4'd1;
          if (header_index == 4'd3) begin
            if (len_bad) begin
              phase_next = PH_CLOSED;
              res_valid  = 1'b1;
              res_kind   = wsfd_pkg::KIND_FAIL;
              res_code   = wsfd_pkg::CODE_PROTO;
            end else if (len_over) begin
              phase_next = PH_CLOSED;
              res_valid  = 1'b1;
              res_kind   = wsfd_pkg::KIND_FAIL;
              res_code   = wsfd_pkg::CODE_BIG;
            end else begin
              if (frame_opcode == wsfd_pkg::OP_CONT && in_fragment) begin
                message_length_next = msg_sum;
              end else if ((frame_opcode == wsfd_pkg::OP_TEXT ||
                            frame_opcode == wsfd_pkg::OP_BIN) && !in_fragment) begin
                message_is_binary_next = (frame_opcode == wsfd_pkg::OP_BIN);
                message_length_next    = hdr_len;
              end
              remaining_length_next = hdr_len;
              mask_position_next    = 2'd0;
              header_index_next     = 4'd0;
              if (hdr_len == '0) begin
                do_finish = 1'b1;
              end else begin
                phase_next = PH_DATA;
              end
            end
          end
        end
        PH_DATA: begin
          mask_position_next    = mask_position + 2'd1;
          remaining_length_next = remaining_length - 64'd1;
          if (remaining_length == 64'd1) begin
            do_finish = 1'b1;
            fin_byte  = data_out;
            fin_has   = 1'b1;
          end else if (frame_opcode != wsfd_pkg::OP_PONG) begin
            res_valid = 1'b1;
            res_byte  = data_out;
            res_has   = 1'b1;
            res_kind  = cur_kind;
          end
        end
        default: begin
        end
      endcase
    end

    if (do_finish) begin
      case (frame_opcode)
        wsfd_pkg::OP_PONG: begin
          phase_next = PH_HDR0;
        end
        wsfd_pkg::OP_CLOSE: begin
          phase_next = PH_CLOSED;
          res_valid  = 1'b1;
          res_byte   = fin_byte;
          res_has    = fin_has;
          res_kind   = wsfd_pkg::KIND_CLOSE;
          res_fend   = 1'b1;
        end
        wsfd_pkg::OP_PING: begin
          phase_next = PH_HDR0;
          res_valid  = 1'b1;
          res_byte   = fin_byte;
          res_has    = fin_has;
          res_kind   = wsfd_pkg::KIND_PING;
          res_fend   = 1'b1;
        end
        default: begin
          res_valid = 1'b1;
          if (frag_bad) begin
            phase_next = PH_CLOSED;
            res_kind   = wsfd_pkg::KIND_FAIL;
            res_code   = wsfd_pkg::CODE_PROTO;
          end else if (frame_opcode == wsfd_pkg::OP_CONT && msg_over) begin
            phase_next = PH_CLOSED;
            res_kind   = wsfd_pkg::KIND_FAIL;
            res_code   = wsfd_pkg::CODE_BIG;
          end else begin
            phase_next       = PH_HDR0;
            in_fragment_next = !frame_fin;
            res_byte         = fin_byte;
            res_has          = fin_has;
            res_kind         = cur_kind;
            res_fend         = 1'b1;
            res_mend         = frame_fin;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HDR0;
      header_index      <= 4'd0;
      frame_fin         <= 1'b0;
      frame_opcode      <= wsfd_pkg::OP_CONT;
      length_code       <= 7'd0;
      frame_masked      <= 1'b0;
      remaining_length  <= '0;
      mask_key          <= 32'd0;
      mask_position     <= 2'd0;
      in_fragment       <= 1'b0;
      message_is_binary <= 1'b0;
      message_length    <= '0;
      header_fault      <= 1'b0;
      max_payload_bytes <= wsfd_pkg::MAX_BYTES_DEFAULT;
      out_valid         <= 1'b0;
    end else begin
      phase             <= phase_next;
      header_index      <= header_index_next;
      frame_fin         <= frame_fin_next;
      frame_opcode      <= frame_opcode_next;
      length_code       <= length_code_next;
      frame_masked      <= frame_masked_next;
      remaining_length  <= remaining_length_next;
      mask_key          <= mask_key_next;
      mask_position     <= mask_position_next;
      in_fragment       <= in_fragment_next;
      message_is_binary <= message_is_binary_next;
      message_length    <= message_length_next;
      header_fault      <= header_fault_next;
      if (cfg_we) begin
        max_payload_bytes <= cfg_data;
      end
      if (accept) begin
        out_valid <= res_valid;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      out_byte <= res_byte;
      out_has  <= res_has;
      out_kind <= res_kind;
      out_fend <= res_fend;
      out_mend <= res_mend;
      out_code <= res_code;
    end
  end

  // a failure result carries no byte and ends no frame
  `WSFD_ASSERT_NOW(a_fail_shape, clk, rst, out_valid && out_code != wsfd_pkg::CODE_NONE, out_kind == wsfd_pkg::KIND_FAIL && !out_has && !out_fend && !out_mend)

  // a closed connection never reopens
  `WSFD_ASSERT_NEXT(a_closed_sticks, clk, rst, phase == PH_CLOSED, phase == PH_CLOSED)

  // payload phase always has bytes left
  `WSFD_ASSERT_NOW(a_data_left, clk, rst, phase == PH_DATA, remaining_length != '0)

  // message end only at the end of a data frame
  `WSFD_ASSERT_NOW(a_mend_kind, clk, rst, out_valid && out_mend, out_fend && (out_kind == wsfd_pkg::KIND_TEXT || out_kind == wsfd_pkg::KIND_BIN))

endmodule
